### rtl/ipc_pkg.sv
package ipc_pkg;

   localparam int MAX_COLS   = 128;
   localparam int MAX_ROWS   = 128;
   localparam int COL_W      = $clog2(MAX_COLS);
   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int CFG_W      = 8;
   localparam int COUNT_W    = 13;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;

   localparam logic [COUNT_W-1:0]   COUNT_MAX      = '1;
   localparam logic [CFG_W-1:0]     CFG_MAX_ROWS   = CFG_W'(MAX_ROWS);
   localparam logic [CFG_W-1:0]     CFG_MAX_COLS   = CFG_W'(MAX_COLS);
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_ROWS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COLS = 1'd1;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_FLUSH,
      ST_DONE
   } state_type;

   // Finished frame count handed from the core to the output register.
   typedef struct packed {
      logic               valid;
      logic [COUNT_W-1:0] count;
   } done_type;

   // A size of zero is taken as one, and a size above the maximum as the maximum.
   function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] max_v);
      logic [CFG_W-1:0] res;
      if (v == '0) begin
         res = CFG_W'(1);
      end else if (v > max_v) begin
         res = max_v;
      end else begin
         res = v;
      end
      return res;
   endfunction

   // Columns are three bits: bit 0 top, bit 1 middle, bit 2 bottom.
   function automatic logic is_isolated(input logic [2:0] left,
                                        input logic [2:0] mid,
                                        input logic [2:0] right);
      return mid[1] && (left == 3'b000) && (right == 3'b000) && !mid[0] && !mid[2];
   endfunction

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
   endfunction

endpackage

### rtl/ipc_line_mem.sv
module ipc_line_mem import ipc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [COL_W-1:0] wr_addr,
   input  logic [1:0]       wr_data,
   input  logic [COL_W-1:0] rd_addr,
   output logic [1:0]       rd_data
);

   logic [1:0]        mem_ff [MAX_COLS];
   logic [MAX_COLS-1:0] valid_ff;
   logic [1:0]        rd_q_ff;
   logic              rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Entries never written since reset read as clear.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // A write and a read of the same entry in one cycle return the new data.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         rd_q_ff   <= '0;
      end else if (wr_en && (wr_addr == rd_addr)) begin
         rd_vld_ff <= 1'b1;
         rd_q_ff   <= wr_data;
      end else begin
         rd_vld_ff <= valid_ff[rd_addr];
         rd_q_ff   <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_q_ff : 2'b00;

   a_wr_fwd: assert property (@(posedge clock) disable iff (reset)
      (wr_en && (wr_addr == rd_addr)) |=> (rd_data == $past(wr_data)))
      else $error("line store read after write returned stale data");

endmodule

### rtl/ipc_core.sv
module ipc_core import ipc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             pixel_set,
   input  logic [CFG_W-1:0] rows,
   input  logic [CFG_W-1:0] cols,
   input  logic             rsp_free,
   output done_type         done,
   output logic             mem_wr_en,
   output logic [COL_W-1:0] mem_wr_addr,
   output logic [1:0]       mem_wr_data,
   output logic [COL_W-1:0] mem_rd_addr,
   input  logic [1:0]       mem_rd_data
);

   state_type          state_ff, state_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [2:0]         win_left_ff, win_left_in;
   logic [2:0]         win_mid_ff, win_mid_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [CFG_W-1:0]   sweep_ff, sweep_in;
   logic               top_en_ff, top_en_in;

   logic       accept;
   logic [2:0] new_col, wl, wm, flush_col;
   logic       first_col, last_col, last_row, frame_end, row_ok;
   logic       judge_pix, flush_hit, flush_last;

   assign accept = req_tvalid && req_tready;

   // Pixel step: the stored column at col_ff is read ahead of its pixel.
   always_comb begin
      row_ok    = (row_ff != '0);
      first_col = (col_ff == '0);
      new_col   = {pixel_set, row_ok & mem_rd_data[0],
                   (row_ff >= ROW_W'(2)) & mem_rd_data[1]};
      wl        = first_col ? 3'b000 : win_left_ff;
      wm        = first_col ? 3'b000 : win_mid_ff;
      last_col  = ({1'b0, col_ff} + CFG_W'(1)) >= cols;
      last_row  = ({1'b0, row_ff} + CFG_W'(1)) >= rows;
      frame_end = last_col && last_row;
      judge_pix = (row_ok && !first_col && is_isolated(wl, wm, new_col)) ||
                  (row_ok && last_col && is_isolated(wm, new_col, 3'b000));
   end

   // Flush sweep over the last row.
   always_comb begin
      flush_col  = (sweep_ff < cols) ?
                   {1'b0, mem_rd_data[0], top_en_ff & mem_rd_data[1]} : 3'b000;
      flush_hit  = (sweep_ff != '0) && is_isolated(win_left_ff, win_mid_ff, flush_col);
      flush_last = (sweep_ff == cols);
   end

   always_comb begin
      row_in      = row_ff;
      col_in      = col_ff;
      win_left_in = win_left_ff;
      win_mid_in  = win_mid_ff;
      count_in    = count_ff;
      sweep_in    = sweep_ff;
      top_en_in   = top_en_ff;
      case (state_ff)
         ST_RUN: begin
            if (accept) begin
               win_left_in = wm;
               win_mid_in  = new_col;
               if (judge_pix) begin
                  count_in = sat_inc(count_ff);
               end
               if (!last_col) begin
                  col_in = col_ff + COL_W'(1);
               end else begin
                  col_in = '0;
                  if (!last_row) begin
                     row_in = row_ff + ROW_W'(1);
                  end else begin
                     row_in      = '0;
                     win_left_in = 3'b000;
                     win_mid_in  = 3'b000;
                     sweep_in    = '0;
                     top_en_in   = row_ok;
                  end
               end
            end
         end
         ST_FLUSH: begin
            win_left_in = win_mid_ff;
            win_mid_in  = flush_col;
            sweep_in    = sweep_ff + CFG_W'(1);
            if (flush_hit) begin
               count_in = sat_inc(count_ff);
            end
            if (flush_last) begin
               win_left_in = 3'b000;
               win_mid_in  = 3'b000;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               count_in = '0;
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_RUN:   if (accept && frame_end) state_in = ST_FLUSH;
         ST_FLUSH: if (flush_last) state_in = ST_DONE;
         ST_DONE:  if (rsp_free) state_in = ST_RUN;
         default:  state_in = ST_RUN;
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = col_ff;
      mem_wr_data = {mem_rd_data[0], pixel_set};
      mem_rd_addr = col_ff;
      done.valid  = 1'b0;
      done.count  = count_ff;
      unique case (state_ff)
         ST_RUN: begin
            req_tready  = 1'b1;
            mem_wr_en   = accept;
            mem_rd_addr = accept ? col_in : col_ff;
         end
         ST_FLUSH: begin
            mem_rd_addr = sweep_ff[COL_W-1:0] + COL_W'(1);
         end
         ST_DONE: begin
            done.valid = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_RUN;
         row_ff      <= '0;
         col_ff      <= '0;
         win_left_ff <= 3'b000;
         win_mid_ff  <= 3'b000;
         count_ff    <= '0;
         sweep_ff    <= '0;
         top_en_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         win_left_ff <= win_left_in;
         win_mid_ff  <= win_mid_in;
         count_ff    <= count_in;
         sweep_ff    <= sweep_in;
         top_en_ff   <= top_en_in;
      end
   end

   a_flush_start: assert property (@(posedge clock) disable iff (reset)
      (accept && frame_end) |=> (state_ff == ST_FLUSH && sweep_ff == '0))
      else $error("frame end did not start the flush sweep");

   a_flush_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_RUN) |-> (row_ff == '0 && col_ff == '0))
      else $error("position not rewound during frame end");

   a_count_mono: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_DONE) |=> (count_ff >= $past(count_ff)))
      else $error("count dropped outside of the result hand-off");

endmodule

### rtl/isolated_pixel_counter_top.sv
// Isolated pixel counter. Pixels of a binary frame arrive in raster order, one
// per req transaction, and the block counts set pixels whose eight neighbors are
// all clear, with everything outside the frame taken as clear. When the last
// pixel of a frame is taken, one rsp transaction carries the count for that
// frame and the count starts over. Frame height and width come from the csr
// registers (index 0 rows, index 1 columns, 1..128 each; 0 is taken as 1 and
// larger values as 128) and should be written between pixels. Within a frame
// one pixel is taken every clock: the two previous rows sit in a 128-entry line
// store with a registered read, whose read address is steered to the next column
// as each pixel is taken. After the last pixel, the last row is judged by a
// sweep through the line store, then the core hands the count to the output
// register; the hand-off waits if the previous count has not yet been taken.
// Pixels of the next frame are accepted while a handed-off count waits on rsp,
// but not while the hand-off itself waits.
module isolated_pixel_counter_top import ipc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [0] pixel_set, rest zero
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [12:0] star_count, rest zero
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_wdata
);

   logic [CFG_W-1:0]   frame_rows_ff, frame_rows_in;
   logic [CFG_W-1:0]   frame_cols_ff, frame_cols_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [CFG_W-1:0] rows, cols;
   logic             rsp_free;
   done_type         done;
   logic             mem_wr_en;
   logic [COL_W-1:0] mem_wr_addr, mem_rd_addr;
   logic [1:0]       mem_wr_data, mem_rd_data;

   // Configuration registers; the decoded sizes are clamped to the legal range.
   always_comb begin
      frame_rows_in = frame_rows_ff;
      frame_cols_in = frame_cols_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_ROWS: frame_rows_in = csr_wdata;
            CSR_FRAME_COLS: frame_cols_in = csr_wdata;
            default:        frame_rows_in = frame_rows_ff;
         endcase
      end
   end

   assign rows = clamp_size(frame_rows_ff, CFG_MAX_ROWS);
   assign cols = clamp_size(frame_cols_ff, CFG_MAX_COLS);

   // The output register frees its slot in the same cycle its transaction completes.
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      if (done.valid && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = done.count;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_rows_ff <= CFG_MAX_ROWS;
         frame_cols_ff <= CFG_MAX_COLS;
         rsp_valid_ff  <= 1'b0;
      end else begin
         frame_rows_ff <= frame_rows_in;
         frame_cols_ff <= frame_cols_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - COUNT_W){1'b0}}, rsp_count_ff};

   ipc_core u_core (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .pixel_set   (req_tdata[0]),
      .rows        (rows),
      .cols        (cols),
      .rsp_free    (rsp_free),
      .done        (done),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   ipc_line_mem u_line_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule
